[hw/rtl/dbmc_pkg.sv]
// Package for the debounced auto-repeat menu cursor.
// It holds the shared types, the register indexes and the reset values.
// It depends on nothing else.
package dbmc_pkg;

    localparam int AGE_WIDTH = 16;
    localparam int CFG_WIDTH = 16;
    localparam int CMP_WIDTH = (AGE_WIDTH > CFG_WIDTH) ? AGE_WIDTH : CFG_WIDTH;
    localparam int POS_WIDTH = 8;

    typedef logic [AGE_WIDTH-1:0] age_t;
    typedef logic [CFG_WIDTH-1:0] ticks_t;
    typedef logic [POS_WIDTH-1:0] pos_t;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE     = 2'd0,
        CFG_REPEAT_DELAY = 2'd1,
        CFG_REPEAT_RATE  = 2'd2,
        CFG_ITEM_COUNT   = 2'd3
    } cfg_index_t;

    localparam ticks_t RST_DEBOUNCE     = ticks_t'(18);
    localparam ticks_t RST_REPEAT_DELAY = ticks_t'(280);
    localparam ticks_t RST_REPEAT_RATE  = ticks_t'(85);
    localparam pos_t   RST_ITEM_COUNT   = pos_t'(4);

    typedef struct packed {
        ticks_t debounce_ticks;
        ticks_t repeat_delay_ticks;
        ticks_t repeat_rate_ticks;
        pos_t   item_count;
    } cfg_t;

    typedef struct packed {
        logic up_level;
        logic down_level;
    } in_t;

    typedef struct packed {
        logic signed [1:0] step;
        logic              up_event;
        logic              down_event;
        pos_t              cursor;
        logic              moved;
    } out_t;

endpackage

[hw/rtl/dbmc_button.sv]
// Debounce and auto-repeat logic for one button, with its level and age registers.
// It uses dbmc_pkg for the age and configuration types.
module dbmc_button (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          tick_en,
    input  logic          level,
    input  dbmc_pkg::cfg_t cfg,
    output logic          step_event
);

    logic          raw_reg, raw_next;
    logic          stable_reg, stable_next;
    dbmc_pkg::age_t settle_reg, settle_next;
    dbmc_pkg::age_t hold_reg, hold_next;
    dbmc_pkg::age_t repeat_reg, repeat_next;

    dbmc_pkg::age_t settle_inc, hold_inc, repeat_inc;
    logic settled, held_long, rate_due;

    always_comb begin
        settle_inc = (settle_reg == '1) ? settle_reg : settle_reg + 1'b1;
        hold_inc   = (hold_reg == '1) ? hold_reg : hold_reg + 1'b1;
        repeat_inc = (repeat_reg == '1) ? repeat_reg : repeat_reg + 1'b1;

        raw_next    = level;
        stable_next = stable_reg;
        settle_next = (level != raw_reg) ? '0 : settle_inc;
        hold_next   = hold_inc;
        repeat_next = repeat_inc;
        step_event  = 1'b0;

        settled   = dbmc_pkg::CMP_WIDTH'(settle_next)
                    >= dbmc_pkg::CMP_WIDTH'(cfg.debounce_ticks);
        held_long = dbmc_pkg::CMP_WIDTH'(hold_inc)
                    >= dbmc_pkg::CMP_WIDTH'(cfg.repeat_delay_ticks);
        rate_due  = dbmc_pkg::CMP_WIDTH'(repeat_inc)
                    >= dbmc_pkg::CMP_WIDTH'(cfg.repeat_rate_ticks);

        if (settled) begin
            if (stable_reg != level) begin
                stable_next = level;
                if (!level) begin
                    hold_next   = '0;
                    repeat_next = '0;
                    step_event  = 1'b1;
                end
            end else if (!stable_reg && held_long && rate_due) begin
                repeat_next = '0;
                step_event  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg    <= 1'b1;
            stable_reg <= 1'b1;
            settle_reg <= '0;
            hold_reg   <= '0;
            repeat_reg <= '0;
        end else if (tick_en) begin
            raw_reg    <= raw_next;
            stable_reg <= stable_next;
            settle_reg <= settle_next;
            hold_reg   <= hold_next;
            repeat_reg <= repeat_next;
        end
    end

endmodule

[hw/rtl/dbmc_cursor.sv]
// Wrapping menu cursor register driven by the up and down step events.
// It uses dbmc_pkg for the position type.
module dbmc_cursor (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          tick_en,
    input  logic          up_event,
    input  logic          down_event,
    input  dbmc_pkg::pos_t item_count,
    output dbmc_pkg::pos_t cursor_next,
    output logic          moved
);

    dbmc_pkg::pos_t cursor_reg;
    logic [dbmc_pkg::POS_WIDTH:0] cand;

    always_comb begin
        moved = up_event ^ down_event;
        cand  = {1'b0, cursor_reg};
        if (down_event && !up_event) begin
            cand = {1'b0, cursor_reg} + 1'b1;
        end else if (up_event && !down_event) begin
            if (cursor_reg == '0) begin
                cand = {1'b0, item_count - 1'b1};
            end else begin
                cand = {1'b0, cursor_reg - 1'b1};
            end
        end
        if (!moved) begin
            cursor_next = cursor_reg;
        end else if (cand >= {1'b0, item_count}) begin
            cursor_next = '0;
        end else begin
            cursor_next = cand[dbmc_pkg::POS_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else if (tick_en) begin
            cursor_reg <= cursor_next;
        end
    end

endmodule

[hw/rtl/debounced_autorepeat_menu_cursor_core.sv]
// Top level of the debounced auto-repeat menu cursor: configuration registers,
// two button units, the cursor unit and the result register.
// It depends on dbmc_pkg, dbmc_button and dbmc_cursor.
//
//   Port group   Direction  Carries
//   s_*          in         one tick beat with the raw up and down levels
//   m_*          out        one result beat per tick: step, events, cursor, moved
//   cfg_*        in         register writes, taken at once
//
// Every tick beat is worked combinationally; its result is registered and shown
// in the following cycle, so one beat is taken per clock while m_ready keeps the result free.
// A waiting result does not block input when m_ready is high in the same cycle.
// Reset restores all levels, ages, the cursor and the register reset values.
module debounced_autorepeat_menu_cursor_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dbmc_pkg::in_t      s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dbmc_pkg::out_t     m_data,
    input  logic               cfg_wr_en,
    input  dbmc_pkg::cfg_index_t cfg_index,
    input  dbmc_pkg::ticks_t   cfg_wr_data
);

    dbmc_pkg::cfg_t cfg_reg;
    logic           m_valid_reg;
    dbmc_pkg::out_t m_data_reg, m_data_next;
    logic           tick_en;
    logic           up_ev, down_ev, moved;
    dbmc_pkg::pos_t cursor_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign tick_en = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks     <= dbmc_pkg::RST_DEBOUNCE;
            cfg_reg.repeat_delay_ticks <= dbmc_pkg::RST_REPEAT_DELAY;
            cfg_reg.repeat_rate_ticks  <= dbmc_pkg::RST_REPEAT_RATE;
            cfg_reg.item_count         <= dbmc_pkg::RST_ITEM_COUNT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dbmc_pkg::CFG_DEBOUNCE:     cfg_reg.debounce_ticks     <= cfg_wr_data;
                dbmc_pkg::CFG_REPEAT_DELAY: cfg_reg.repeat_delay_ticks <= cfg_wr_data;
                dbmc_pkg::CFG_REPEAT_RATE:  cfg_reg.repeat_rate_ticks  <= cfg_wr_data;
                dbmc_pkg::CFG_ITEM_COUNT: begin
                    cfg_reg.item_count <= cfg_wr_data[dbmc_pkg::POS_WIDTH-1:0];
                end
                default: ;
            endcase
        end
    end

    dbmc_button u_up (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_en    (tick_en),
        .level      (s_data.up_level),
        .cfg        (cfg_reg),
        .step_event (up_ev)
    );

    dbmc_button u_down (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_en    (tick_en),
        .level      (s_data.down_level),
        .cfg        (cfg_reg),
        .step_event (down_ev)
    );

    dbmc_cursor u_cursor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (tick_en),
        .up_event    (up_ev),
        .down_event  (down_ev),
        .item_count  (cfg_reg.item_count),
        .cursor_next (cursor_next),
        .moved       (moved)
    );

    always_comb begin
        m_data_next.step       = 2'(down_ev) - 2'(up_ev);
        m_data_next.up_event   = up_ev;
        m_data_next.down_event = down_ev;
        m_data_next.cursor     = cursor_next;
        m_data_next.moved      = moved;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tick_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_en) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

[hw/rtl/dbmc_checker.sv]
// Port-level checks for the debounced auto-repeat menu cursor core.
// It depends on dbmc_pkg and is bound to the top level below.
module dbmc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input dbmc_pkg::out_t     m_data
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("Input stalled with an empty result register.");

    a_beat_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("Accepted beat gave no result.");

    a_step_matches_events: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.step == 2'(m_data.down_event) - 2'(m_data.up_event))
                     && (m_data.moved == (m_data.step != 2'd0))))
        else $error("Step, events and moved disagree.");

endmodule

bind debounced_autorepeat_menu_cursor_core dbmc_checker u_dbmc_checker (.*);
